### rtl/mi3_pkg.sv
// Package for the 3x3 matrix inverse: field widths and shared constants.
// No dependencies.
package mi3_pkg;
    localparam int ElemW  = 24;
    localparam int OutW   = 32;
    localparam int AdjW   = 49;
    localparam int DetW   = 75;
    localparam int FracW  = 20;
    localparam int QuotW  = 33;
    localparam logic [31:0] ThreshReset = 32'd109951;
endpackage

### rtl/matrix_inverse_3x3_top.sv
// Top level of the 3x3 matrix inverse pipeline.
// Depends on mi3_pkg.
// Registers from the edge that accepts an input word to the edge that presents its
// result word: five arithmetic stages, the divider set-up stage and 34 divider
// stages, then the output register.
// Throughput: one matrix word per cycle; the restoring divider is unrolled as one
// register stage per quotient bit, nine lanes wide, so the pipeline never iterates.
// The whole pipeline advances together and halts while the output register is full
// and not taken. Reset clears every valid bit and loads the threshold with 109951.
module matrix_inverse_3x3_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,   // a_r1c1 .. a_r3c3, 24 bits each, lowest first
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // inv_r1c1 .. inv_r3c3, 32 bits each, lowest first
    output logic         m_tuser    // singular
);
    localparam int NDiv = mi3_pkg::QuotW + 1;   // quotient bits plus rounding bit
    localparam int NSt  = 6 + NDiv;

    logic [31:0] thresh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= mi3_pkg::ThreshReset;
        else if (cfg_we)
            thresh_reg <= cfg_wdata;
    end

    // One enable moves every stage; the final output register is a skid-free
    // register that accepts while it is empty or being emptied.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [NSt-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSt-2:0], s_tvalid};
    end

    // Stage 1: capture elements.
    logic signed [23:0] a_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < 9; i++)
                a_reg[i] <= s_tdata[24*i +: 24];
    end

    // Stage 2: eighteen 24x24 products for the adjugate.
    logic signed [47:0] p_reg [18];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]  <= a_reg[8] * a_reg[4];  p_reg[1]  <= a_reg[7] * a_reg[5];
            p_reg[2]  <= a_reg[8] * a_reg[1];  p_reg[3]  <= a_reg[7] * a_reg[2];
            p_reg[4]  <= a_reg[5] * a_reg[1];  p_reg[5]  <= a_reg[4] * a_reg[2];
            p_reg[6]  <= a_reg[8] * a_reg[3];  p_reg[7]  <= a_reg[6] * a_reg[5];
            p_reg[8]  <= a_reg[8] * a_reg[0];  p_reg[9]  <= a_reg[6] * a_reg[2];
            p_reg[10] <= a_reg[5] * a_reg[0];  p_reg[11] <= a_reg[3] * a_reg[2];
            p_reg[12] <= a_reg[7] * a_reg[3];  p_reg[13] <= a_reg[6] * a_reg[4];
            p_reg[14] <= a_reg[7] * a_reg[0];  p_reg[15] <= a_reg[6] * a_reg[1];
            p_reg[16] <= a_reg[4] * a_reg[0];  p_reg[17] <= a_reg[3] * a_reg[1];
        end
    end

    logic signed [23:0] c2_reg [3];
    logic signed [23:0] c3_reg [3];
    logic signed [mi3_pkg::AdjW-1:0] adj_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg[0] <= a_reg[0]; c2_reg[1] <= a_reg[3]; c2_reg[2] <= a_reg[6];
            c3_reg <= c2_reg;
        end
    end

    // Stage 3: adjugate entries, signs folded in.
    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < 9; i++)
            begin
                if (i == 1 || i == 3 || i == 5 || i == 7)
                    adj_reg[i] <= 49'(p_reg[2*i+1]) - 49'(p_reg[2*i]);
                else
                    adj_reg[i] <= 49'(p_reg[2*i]) - 49'(p_reg[2*i+1]);
            end
    end

    // Stage 4: column products, split as 24x29 (upper adjugate bits) and 24x21
    // (lower twenty bits, unsigned) so that both halves stay exact.
    logic signed [52:0] cph_reg [3];
    logic signed [44:0] cpl_reg [3];
    logic signed [mi3_pkg::AdjW-1:0] adj4_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cph_reg[i] <= 53'(c3_reg[i]) * 53'($signed(adj_reg[i][48:20]));
                cpl_reg[i] <= 45'(c3_reg[i]) * 45'($signed({1'b0, adj_reg[i][19:0]}));
            end
            adj4_reg <= adj_reg;
        end
    end

    // Stage 5: exact sum, floored to 2^-40 units.
    logic signed [46:0] lo_sum;
    logic signed [mi3_pkg::DetW-1:0] det_sum;
    logic signed [mi3_pkg::DetW-1:0] det_reg;
    logic signed [mi3_pkg::AdjW-1:0] adj5_reg [9];
    assign lo_sum  = 47'(cpl_reg[0]) + 47'(cpl_reg[1]) + 47'(cpl_reg[2]);
    assign det_sum = 75'(cph_reg[0]) + 75'(cph_reg[1]) + 75'(cph_reg[2])
                   + 75'(lo_sum >>> 20);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg  <= det_sum;
            adj5_reg <= adj4_reg;
        end
    end

    // Magnitudes for the divider set-up stage and the singular check.
    logic [mi3_pkg::DetW-1:0] det_mag;
    logic [mi3_pkg::AdjW-1:0] adj_abs [9];
    assign det_mag = det_reg[74] ? 75'(-det_reg) : 75'(det_reg);
    always_comb
    begin
        for (int j = 0; j < 9; j++)
            adj_abs[j] = adj5_reg[j][mi3_pkg::AdjW-1] ? 49'(-adj5_reg[j]) : 49'(adj5_reg[j]);
    end

    // Divider: restoring, one quotient bit per stage. The quotient of |adj| << 21
    // by |det| is taken in units of 2^-21; the remainder starts with |adj| >> 13 and
    // the last 34 dividend bits are shifted in. A start remainder not below |det|
    // means the result is far out of range and saturates. The last bit rounds half
    // away from zero.
    localparam int DvW = 57;   // |det| < 2^56
    localparam int NumW = NDiv;
    logic [DvW-1:0] dv_reg [NDiv+1];
    logic           sg_reg [NDiv+1];
    logic [NumW-1:0] nm_reg [NDiv+1][9];
    logic [DvW:0]    rm_reg [NDiv+1][9];
    logic [NDiv-1:0] q_reg  [NDiv+1][9];
    logic            ng_reg [NDiv+1][9];
    logic            ov_reg [NDiv+1][9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= det_mag[DvW-1:0];
            sg_reg[0] <= (det_mag == '0) || (det_mag < 75'(thresh_reg));
            for (int j = 0; j < 9; j++)
            begin
                nm_reg[0][j] <= {adj_abs[j][12:0], 21'd0};
                rm_reg[0][j] <= {22'd0, adj_abs[j][48:13]};
                q_reg[0][j]  <= '0;
                ng_reg[0][j] <= adj5_reg[j][48] ^ det_reg[74];
                ov_reg[0][j] <= {22'd0, adj_abs[j][48:13]} >= {1'b0, det_mag[DvW-1:0]};
            end
            for (int s = 0; s < NDiv; s++)
            begin
                dv_reg[s+1] <= dv_reg[s];
                sg_reg[s+1] <= sg_reg[s];
                for (int j = 0; j < 9; j++)
                begin
                    logic [DvW:0] t;
                    t = {rm_reg[s][j][DvW-1:0], nm_reg[s][j][NumW-1]};
                    ng_reg[s+1][j] <= ng_reg[s][j];
                    ov_reg[s+1][j] <= ov_reg[s][j];
                    nm_reg[s+1][j] <= {nm_reg[s][j][NumW-2:0], 1'b0};
                    if (t >= {1'b0, dv_reg[s]})
                    begin
                        rm_reg[s+1][j] <= t - {1'b0, dv_reg[s]};
                        q_reg[s+1][j]  <= {q_reg[s][j][NDiv-2:0], 1'b1};
                    end
                    else
                    begin
                        rm_reg[s+1][j] <= t;
                        q_reg[s+1][j]  <= {q_reg[s][j][NDiv-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output register: round, saturate, zero singular results, pack.
    logic [287:0] data_next;
    always_comb
    begin
        logic [NDiv-1:0] qq;
        logic [33:0] m;
        data_next = '0;
        for (int j = 0; j < 9; j++)
        begin
            qq = q_reg[NDiv][j];
            m  = 34'(qq[NDiv-1:1]) + 34'(qq[0]);
            if (ov_reg[NDiv][j])
                m = 34'h80000001;
            if (ng_reg[NDiv][j])
                data_next[32*j +: 32] = (m > 34'h80000000) ? 32'h80000000
                                                            : 32'(-m);
            else
                data_next[32*j +: 32] = (m > 34'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
            if (sg_reg[NDiv])
                data_next[32*j +: 32] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (adv)
            m_tvalid <= v_reg[NSt-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata <= data_next;
            m_tuser <= sg_reg[NDiv];
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output lost");
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0) else $error("singular data not zero");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg)) else $error("pipe moved in stall");
endmodule
